>>> design/packed_vlan_id_table_defines.svh
// Assertion helpers shared by the table RTL.
`ifndef PACKED_VLAN_ID_TABLE_DEFINES_SVH
`define PACKED_VLAN_ID_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle during reset.
`define PVID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle during reset.
`define PVID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pvid_pkg.sv
package pvid_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 12;

  localparam logic [15:0] EMPTY_SLOT = 16'hffff;

  typedef enum logic [2:0] {
    CMD_FIND   = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } pvid_cmd_e;

  // One write port and one read port, which can both be used in the same cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pvid_ram_req_t;

endpackage

>>> design/pvid_ram.sv
module pvid_ram (
  input  logic                            clk_i,
  input  pvid_pkg::pvid_ram_req_t         req_i,
  output logic [pvid_pkg::KEY_W-1:0]      rd_data_o
);

  logic [pvid_pkg::KEY_W-1:0] mem [pvid_pkg::MAX_ENTRIES];
  logic [pvid_pkg::KEY_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/packed_vlan_id_table.sv
// Packed VLAN ID table: up to MAX_ENTRIES distinct 12-bit VLAN IDs held in
// slots 0 .. entry_count-1 of one single-write, single-read memory, one
// command beat in, one result beat out. The memory walks one slot per cycle:
// find and create walk from slot 0 to a hit or to the count, delete from the
// slot after the deleted one to the count, moving each key down by one; a
// read past the count, clear, a bad delete and an unknown command go to the
// result without a memory walk. Slots at or above the count read as 0xffff
// straight from the count, so reset and clear need no sweep over the memory
// and the block takes commands from the first cycle after reset. A command
// is taken while the previous result still waits in the output register.
`include "packed_vlan_id_table_defines.svh"

module packed_vlan_id_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [11:0] vlan_key, [23:12] slot_index
  input  logic [23:0] s_axis_tdata_i,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] ok, [12:1] found_index, [28:13] read_key, [41:29] entry_count, [47:42] zero
  output logic [47:0] m_axis_tdata_o
);

  localparam int ADDR_W = pvid_pkg::ADDR_W;
  localparam int CNT_W  = pvid_pkg::CNT_W;
  localparam int KEY_W  = pvid_pkg::KEY_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_READ,
    ST_FIN
  } state_e;

  state_e                  state_q, state_d;
  pvid_pkg::pvid_cmd_e     cmd_q, cmd_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic                    pend_q, pend_d;
  logic [ADDR_W-1:0]       pend_addr_q, pend_addr_d;
  logic                    res_ok_q, res_ok_d;
  logic [11:0]             res_found_q, res_found_d;
  logic [15:0]             res_rkey_q, res_rkey_d;
  logic                    m_valid_q, m_valid_d;
  logic [47:0]             m_data_q, m_data_d;

  pvid_pkg::pvid_ram_req_t ram_req;
  logic [KEY_W-1:0]        rd_data;

  logic [11:0]             in_key;
  logic [11:0]             in_idx;
  logic                    in_beat;
  logic                    hit;

  assign in_key  = s_axis_tdata_i[11:0];
  assign in_idx  = s_axis_tdata_i[23:12];
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;
  assign hit     = pend_q && (rd_data == key_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  pvid_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // command sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    res_ok_d    = res_ok_q;
    res_found_d = res_found_q;
    res_rkey_d  = res_rkey_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    ram_req     = '0;

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          cmd_d       = pvid_pkg::pvid_cmd_e'(s_axis_tuser_i);
          key_d       = KEY_W'(in_key);
          pend_d      = 1'b0;
          res_ok_d    = 1'b0;
          res_found_d = '0;
          res_rkey_d  = pvid_pkg::EMPTY_SLOT;
          state_d     = ST_FIN;
          case (pvid_pkg::pvid_cmd_e'(s_axis_tuser_i))
            pvid_pkg::CMD_FIND, pvid_pkg::CMD_CREATE: begin
              ptr_d   = '0;
              state_d = ST_SEARCH;
            end
            pvid_pkg::CMD_DELETE: begin
              if (13'(in_idx) < 13'(count_q)) begin
                ptr_d   = CNT_W'(in_idx) + CNT_W'(1);
                state_d = ST_SHIFT;
              end
            end
            pvid_pkg::CMD_READ: begin
              if (13'(in_idx) < 13'(pvid_pkg::MAX_ENTRIES)) begin
                res_ok_d = 1'b1;
                // slots past the count read as the empty marker
                if (13'(in_idx) < 13'(count_q)) begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = in_idx[ADDR_W-1:0];
                  state_d       = ST_READ;
                end
              end
            end
            pvid_pkg::CMD_CLEAR: begin
              count_d  = '0;
              res_ok_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // one slot issued and one compared per cycle
      ST_SEARCH: begin
        pend_d = 1'b0;
        if (hit) begin
          if (cmd_q == pvid_pkg::CMD_FIND) begin
            res_ok_d    = 1'b1;
            res_found_d = 12'(pend_addr_q);
          end
          state_d = ST_FIN;
        end else if (ptr_q == count_q) begin
          // miss: create appends when there is room
          if (cmd_q == pvid_pkg::CMD_CREATE &&
              count_q != CNT_W'(pvid_pkg::MAX_ENTRIES)) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = count_q[ADDR_W-1:0];
            ram_req.wdata = key_q;
            res_found_d   = 12'(count_q);
            res_ok_d      = 1'b1;
            count_d       = count_q + CNT_W'(1);
          end
          state_d = ST_FIN;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_q[ADDR_W-1:0];
          pend_d        = 1'b1;
          pend_addr_d   = ptr_q[ADDR_W-1:0];
          ptr_d         = ptr_q + CNT_W'(1);
        end
      end

      // read slot n while slot n-2 takes slot n-1, read the cycle before
      ST_SHIFT: begin
        pend_d = 1'b0;
        if (pend_q) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pend_addr_q - ADDR_W'(1);
          ram_req.wdata = rd_data;
        end
        if (ptr_q == count_q) begin
          count_d  = count_q - CNT_W'(1);
          res_ok_d = 1'b1;
          state_d  = ST_FIN;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_q[ADDR_W-1:0];
          pend_d        = 1'b1;
          pend_addr_d   = ptr_q[ADDR_W-1:0];
          ptr_d         = ptr_q + CNT_W'(1);
        end
      end

      ST_READ: begin
        res_rkey_d = 16'(rd_data);
        state_d    = ST_FIN;
      end

      // hand the result to the output register once it is free
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, 13'(count_q), res_rkey_q, res_found_q, res_ok_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    res_ok_q    <= res_ok_d;
    res_found_q <= res_found_d;
    res_rkey_q  <= res_rkey_d;
    m_data_q    <= m_data_d;
  end

  `PVID_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(pvid_pkg::MAX_ENTRIES), "count over capacity")
  `PVID_ASSERT_IMP(a_write_busy, ram_req.we, state_q != ST_IDLE, "memory write while idle")
  `PVID_ASSERT_NXT(a_clear_empties, in_beat && s_axis_tuser_i == 3'(pvid_pkg::CMD_CLEAR), count_q == '0, "clear left entries")
  `PVID_ASSERT_NXT(a_create_grows, state_q == ST_SEARCH && ram_req.we, count_q == $past(count_q) + CNT_W'(1), "append did not grow count")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

  // Unknown command codes, all of them answered by the table without any change
  localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
  localparam logic [2:0] CMD_BAD_LAST  = 3'd7;

  // Cycles without any beat on either side before the run is abandoned
  localparam int unsigned HANG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [pvid_pkg::CNT_W-1:0]  entry_count;
    logic [15:0]                 read_key;
    logic [pvid_pkg::ADDR_W-1:0] found_index;
    logic                        ok;
  } table_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  // Mirror of the table contents
  logic [15:0] mirror_slots [pvid_pkg::MAX_ENTRIES];
  int unsigned mirror_count;

  table_result_t expected_results [$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   ready_hold = 0;
  bit            idling_on = 1'b1;

  always #1 clk_i = ~clk_i;

  packed_vlan_id_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // Apply one command to the mirror and return the result it must produce
  function automatic table_result_t table_apply(logic [2:0] op, logic [11:0] key,
                                                logic [11:0] idx);
    table_result_t res;
    int unsigned   hit;
    bit            present;
    res.ok          = 1'b0;
    res.found_index = '0;
    res.read_key    = pvid_pkg::EMPTY_SLOT;
    present = 1'b0;
    hit = 0;
    if (op == pvid_pkg::CMD_FIND || op == pvid_pkg::CMD_CREATE) begin
      for (int unsigned i = 0; i < mirror_count; i++) begin
        if (!present && mirror_slots[i] == {4'h0, key}) begin
          present = 1'b1;
          hit = i;
        end
      end
    end
    case (op)
      pvid_pkg::CMD_FIND: begin
        if (present) begin
          res.ok = 1'b1;
          res.found_index = hit[pvid_pkg::ADDR_W-1:0];
        end
      end
      pvid_pkg::CMD_CREATE: begin
        if (!present && mirror_count < pvid_pkg::MAX_ENTRIES) begin
          res.found_index = mirror_count[pvid_pkg::ADDR_W-1:0];
          mirror_slots[mirror_count] = {4'h0, key};
          mirror_count++;
          res.ok = 1'b1;
        end
      end
      pvid_pkg::CMD_DELETE: begin
        if (idx < mirror_count) begin
          for (int unsigned i = idx; i + 1 < mirror_count; i++)
            mirror_slots[i] = mirror_slots[i + 1];
          mirror_count--;
          mirror_slots[mirror_count] = pvid_pkg::EMPTY_SLOT;
          res.ok = 1'b1;
        end
      end
      pvid_pkg::CMD_READ: begin
        // 12-bit index never reaches past the table
        res.read_key = mirror_slots[idx];
        res.ok = 1'b1;
      end
      pvid_pkg::CMD_CLEAR: begin
        foreach (mirror_slots[i]) mirror_slots[i] = pvid_pkg::EMPTY_SLOT;
        mirror_count = 0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.entry_count = mirror_count[pvid_pkg::CNT_W-1:0];
    return res;
  endfunction

  // Send one command beat; called and returning on a falling edge
  task automatic push_cmd(logic [2:0] op, logic [11:0] key, logic [11:0] idx);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, key};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(table_apply(op, key, idx));
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Result side: compare every beat with the oldest expectation
  always @(posedge clk_i) begin
    table_result_t want;
    table_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[41:0];
      if (expected_results.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("ok", want.ok, got.ok);
        check_field("found_index", want.found_index, got.found_index);
        check_field("read_key", want.read_key, got.read_key);
        check_field("entry_count", want.entry_count, got.entry_count);
      end
    end
  end

  // Result side backpressure in bursts
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(1, 14) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Hang detection
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Empty table: reads, misses, bad delete and unknown commands
  task automatic test_empty_table();
    push_cmd(pvid_pkg::CMD_READ, 12'hfff, 12'd0);
    push_cmd(pvid_pkg::CMD_READ, 12'h000, 12'hfff);
    push_cmd(pvid_pkg::CMD_FIND, 12'h000, 12'hfff);
    push_cmd(pvid_pkg::CMD_DELETE, 12'hfff, 12'd0);
    for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++)
      push_cmd(c[2:0], 12'hfff, 12'hfff);
  endtask

  // Appends, duplicates, hits and misses
  task automatic test_create_find();
    push_cmd(pvid_pkg::CMD_CREATE, 12'h000, 12'hfff);
    push_cmd(pvid_pkg::CMD_CREATE, 12'hfff, 12'h000);
    push_cmd(pvid_pkg::CMD_CREATE, 12'h000, 12'h000);
    push_cmd(pvid_pkg::CMD_CREATE, 12'h5a5, 12'h000);
    push_cmd(pvid_pkg::CMD_FIND, 12'hfff, 12'h000);
    push_cmd(pvid_pkg::CMD_FIND, 12'h5a5, 12'h000);
    push_cmd(pvid_pkg::CMD_FIND, 12'h123, 12'h000);
    push_cmd(pvid_pkg::CMD_READ, 12'h000, 12'd1);
    push_cmd(pvid_pkg::CMD_READ, 12'h000, 12'd3);
  endtask

  // Deletes at the head and tail, bad indices, then clear
  task automatic test_delete_clear();
    push_cmd(pvid_pkg::CMD_CREATE, 12'ha5a, 12'h000);
    push_cmd(pvid_pkg::CMD_DELETE, 12'h000, 12'd0);
    push_cmd(pvid_pkg::CMD_DELETE, 12'h000, 12'd2);
    push_cmd(pvid_pkg::CMD_DELETE, 12'h000, 12'd2);
    push_cmd(pvid_pkg::CMD_DELETE, 12'h000, 12'hfff);
    push_cmd(pvid_pkg::CMD_READ, 12'h000, 12'd0);
    push_cmd(pvid_pkg::CMD_CLEAR, 12'hfff, 12'hfff);
    push_cmd(pvid_pkg::CMD_READ, 12'h000, 12'd0);
    push_cmd(pvid_pkg::CMD_FIND, 12'hfff, 12'h000);
  endtask

  // Mostly well-formed table traffic with some noise
  task automatic test_random_traffic(int unsigned beats);
    int unsigned pick;
    logic [11:0] key;
    logic [11:0] idx;
    for (int unsigned n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 99);
      key  = 12'($urandom_range(0, 4095));
      idx  = 12'($urandom_range(0, 4095));
      if (pick < 36) begin
        if (mirror_count > 0 && $urandom_range(0, 3) == 0)
          key = mirror_slots[$urandom_range(0, mirror_count - 1)][11:0];
        push_cmd(pvid_pkg::CMD_CREATE, key, idx);
      end else if (pick < 56) begin
        if (mirror_count > 0 && $urandom_range(0, 1) == 0)
          key = mirror_slots[$urandom_range(0, mirror_count - 1)][11:0];
        push_cmd(pvid_pkg::CMD_FIND, key, idx);
      end else if (pick < 73) begin
        if (mirror_count > 0 && $urandom_range(0, 4) != 0)
          idx = 12'($urandom_range(0, mirror_count - 1));
        push_cmd(pvid_pkg::CMD_DELETE, key, idx);
      end else if (pick < 90) begin
        if ($urandom_range(0, 4) < 3)
          idx = 12'($urandom_range(0, mirror_count));
        push_cmd(pvid_pkg::CMD_READ, key, idx);
      end else if (pick < 95 || mirror_count > 48) begin
        push_cmd(pvid_pkg::CMD_CLEAR, key, idx);
      end else begin
        push_cmd(3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST)), key, idx);
      end
    end
  endtask

  // Wait for every result, then let the block settle
  task automatic test_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    foreach (mirror_slots[i]) mirror_slots[i] = pvid_pkg::EMPTY_SLOT;
    mirror_count = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_create_find();
    test_delete_clear();
    test_random_traffic(85);
    idling_on = 1'b0;
    test_random_traffic(30);
    test_drain();
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
